@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked property on the rising clock edge, disabled while reset is asserted.
`define ILPR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// Checked property on the rising clock edge, also checked during reset.
`define ILPR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("assertion failed");

`else

`define ILPR_ASSERT(lbl, clk, rst_n, prop)
`define ILPR_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hdl/ilpr_pkg.sv @@
// ---------------------------------------------------------------------------
// ilpr_pkg
// Types and constants of the length-prefixed two-wire read sequencer.
// ---------------------------------------------------------------------------
package ilpr_pkg;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_ADDR1 = 4'd1,
		PH_ACK1  = 4'd2,
		PH_LEN   = 4'd3,
		PH_ADDR2 = 4'd4,
		PH_ACK2  = 4'd5,
		PH_DATA  = 4'd6,
		PH_LAST  = 4'd7,
		PH_STOP  = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_START   = 3'd1,
		CMD_SEND    = 3'd2,
		CMD_RX_NACK = 3'd3,
		CMD_RX_ACK  = 3'd4,
		CMD_RESTART = 3'd5,
		CMD_STOP    = 3'd6
	} cmd_t;

	// Kind of input item.
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_EVENT = 1'b1;

	// Status code that the bus controller reports for an acknowledged address.
	localparam logic [7:0] ACK_STATUS = 8'h40;
	// Reset value of the read address register.
	localparam logic [7:0] ADDR_RESET = 8'h03;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] byte_index;
		logic [7:0] msg_len;
	} state_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] tx_byte;
		logic       write_valid;
		logic [7:0] write_index;
		logic [7:0] write_data;
		logic       done_res;
	} result_t;

endpackage

@@ hdl/ilpr_step.sv @@
// ---------------------------------------------------------------------------
// ilpr_step
// Next-state and result logic for one input item of the read sequencer.
// ---------------------------------------------------------------------------
module ilpr_step (
	input  ilpr_pkg::state_t  st,
	input  logic              action,
	input  logic [7:0]        bus_status,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        read_address_byte,
	output ilpr_pkg::state_t  st_nxt,
	output ilpr_pkg::result_t res
);
	import ilpr_pkg::*;

	logic [7:0] idx_inc;

	// Index after this byte, wrapping at eight bits.
	assign idx_inc = st.byte_index + 8'd1;

	always_comb begin
		st_nxt = st;
		res    = '0;
		res.command = CMD_NONE;

		if (action == ACT_START) begin
			st_nxt.phase      = PH_ADDR1;
			st_nxt.byte_index = '0;
			st_nxt.msg_len    = '0;
			res.command       = CMD_START;
		end else begin
			case (st.phase)
				PH_ADDR1: begin
					res.tx_byte  = read_address_byte;
					res.command  = CMD_SEND;
					st_nxt.phase = PH_ACK1;
				end
				PH_ACK1: begin
					if (bus_status == ACK_STATUS) begin
						res.command  = CMD_RX_NACK;
						st_nxt.phase = PH_LEN;
					end else begin
						res.command  = CMD_RESTART;
						st_nxt.phase = PH_ADDR1;
					end
				end
				PH_LEN: begin
					st_nxt.msg_len = rx_byte;
					if (rx_byte == 8'd0) begin
						st_nxt.phase = PH_STOP;
					end else begin
						res.command  = CMD_RESTART;
						st_nxt.phase = PH_ADDR2;
					end
				end
				PH_ADDR2: begin
					res.tx_byte  = read_address_byte;
					res.command  = CMD_SEND;
					st_nxt.phase = PH_ACK2;
				end
				PH_ACK2: begin
					if (bus_status != ACK_STATUS) begin
						res.command  = CMD_RESTART;
						st_nxt.phase = PH_ADDR2;
					end else begin
						res.command  = CMD_RX_ACK;
						st_nxt.phase = PH_DATA;
					end
				end
				PH_DATA: begin
					res.write_valid   = 1'b1;
					res.write_index   = st.byte_index;
					res.write_data    = rx_byte;
					st_nxt.byte_index = idx_inc;
					// The new index is below length minus one exactly when the
					// wrapped index plus one is below the length.
					if ({1'b0, idx_inc} + 9'd1 < {1'b0, st.msg_len}) begin
						res.command = CMD_RX_ACK;
					end else begin
						res.command  = CMD_RX_NACK;
						st_nxt.phase = PH_LAST;
					end
				end
				PH_LAST: begin
					res.write_valid = 1'b1;
					res.write_index = st.byte_index;
					res.write_data  = rx_byte;
					st_nxt.phase    = PH_STOP;
				end
				default: begin
				end
			endcase
			if (st_nxt.phase == PH_STOP) begin
				res.command  = CMD_STOP;
				res.done_res = 1'b1;
			end
		end
	end

endmodule

@@ hdl/ilpr_out_reg.sv @@
// ---------------------------------------------------------------------------
// ilpr_out_reg
// Result register with valid/ready handshake on both sides.
// ---------------------------------------------------------------------------
module ilpr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ilpr_pkg::result_t in_res,
	output logic              out_valid,
	input  logic              out_ready,
	output ilpr_pkg::result_t out_res
);
	import ilpr_pkg::*;

	logic    valid_q;
	result_t res_q;

	// A new result may enter when the register is empty or is drained now.
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= in_res;
		end
	end

endmodule

@@ hdl/i2c_master_length_prefixed_read.sv @@
// ---------------------------------------------------------------------------
// i2c_master_length_prefixed_read
// Command sequencer for a two-wire master reading a length-prefixed message.
// ---------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per start request or bus event. s_tuser
//   is the kind (0 start request, 1 bus controller event), s_tdata holds the
//   reported status code and the received byte.
//   Every accepted item yields exactly one result on the master stream: the
//   bus command to issue, the byte to send, an optional buffer write of a
//   payload byte (m_tuser flags it) and, on m_tlast, the end of the transfer
//   with STOP.
//   The address byte sent in both address phases comes from a single
//   register written over the cfg channel; it resets to 0x03. cfg_ready is
//   always high.
// Timing:
//   One item is taken per cycle while the result register can accept it. The
//   result is registered and appears in the cycle after the slave transfer.
//   When the receiver stalls, the result register holds its item and s_tready
//   drops until it is taken; a result leaving in the same cycle lets the next
//   item in without a bubble.
// Reset:
//   arst_n clears the phase to idle, the byte index and length to zero, the
//   result register to empty and the address register to 0x03.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_length_prefixed_read (
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] bus_status, [15:8] rx_byte
	input  logic        s_tuser,   // [0] action
	// Results.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [2:0] command, [10:3] tx_byte,
	                               // [18:11] write_index, [26:19] write_data,
	                               // [31:27] zero
	output logic        m_tuser,   // [0] write_valid
	output logic        m_tlast,   // done_res
	// Address register write.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import ilpr_pkg::*;

	state_t     st_q;
	state_t     st_nxt;
	result_t    res_nxt;
	result_t    res_out;
	logic [7:0] read_addr_q;
	logic       s_fire;
	logic       s_start;
	logic [2:0] m_cmd;
	logic       m_write_ok;
	logic       st_cnt_clear;

	// The address register is writable at any time; the port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_addr_q <= ADDR_RESET;
		end else if (cfg_valid) begin
			read_addr_q <= cfg_data;
		end
	end

	assign s_fire = s_tvalid && s_tready;

	// Sequence state advances once per accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_IDLE;
			st_q.byte_index <= '0;
			st_q.msg_len    <= '0;
		end else if (s_fire) begin
			st_q <= st_nxt;
		end
	end

	ilpr_step u_step (
		.st                (st_q),
		.action            (s_tuser),
		.bus_status        (s_tdata[7:0]),
		.rx_byte           (s_tdata[15:8]),
		.read_address_byte (read_addr_q),
		.st_nxt            (st_nxt),
		.res               (res_nxt)
	);

	// The result register decouples the two streams.
	ilpr_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_res    (res_nxt),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res_out)
	);

	assign m_tdata = {5'd0, res_out.write_data, res_out.write_index,
		res_out.tx_byte, res_out.command};
	assign m_tuser = res_out.write_valid;
	assign m_tlast = res_out.done_res;

	// Terms used by the checks below.
	assign s_start      = s_fire && (s_tuser == ACT_START);
	assign m_cmd        = m_tdata[2:0];
	assign m_write_ok   = (m_cmd == CMD_RX_ACK) || (m_cmd == CMD_RX_NACK) ||
		(m_cmd == CMD_STOP);
	assign st_cnt_clear = (st_q.byte_index == 8'd0) && (st_q.msg_len == 8'd0);

	// A start request always comes out as START in the next cycle.
	`ILPR_ASSERT(a_start_cmd, clk, arst_n, s_start |=> (m_tvalid && m_cmd == CMD_START))
	// The end-of-transfer flag goes with STOP and only with it.
	`ILPR_ASSERT(a_done_stop, clk, arst_n, m_tvalid |-> (m_tlast == (m_cmd == CMD_STOP)))
	// Payload writes happen only while receiving or at the final STOP.
	`ILPR_ASSERT(a_write_cmd, clk, arst_n, (m_tvalid && m_tuser) |-> m_write_ok)
	// Idle is only reached from reset, so the counters are clear there.
	`ILPR_ASSERT_ALWAYS(a_idle_clear, clk, (st_q.phase == PH_IDLE) |-> st_cnt_clear)

endmodule
